// ===== rtl/gcl_pkg.sv =====
package gcl_pkg;

   // Default operand and result width.
   localparam int DATA_BITS_DEF = 31;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new operand pair
      logic gcd_step;   // one binary gcd reduction step
      logic div_start;  // latch the gcd and prepare the divider
      logic div_step;   // one restoring divide step
      logic mul_start;  // clear the product accumulator
      logic mul_step;   // one shift and add multiply step
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic gcd_done;   // one working value has reached zero
      logic any_zero;   // an operand of the current item is zero
      logic last_step;  // the step counter is on its final step
   } status_type;

endpackage

// ===== rtl/gcl_ctrl.sv =====
module gcl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               out_free,
   output logic               out_load,
   input  gcl_pkg::status_type status,
   output gcl_pkg::cmd_type    cmd
);
   import gcl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               // With a zero operand the lcm is zero and no divide is needed.
               state_in = status.any_zero ? ST_FINISH : ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.last_step) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gcl_datapath.sv =====
module gcl_datapath #(
   parameter int DATA_BITS = gcl_pkg::DATA_BITS_DEF
) (
   input  logic                 clock,
   input  gcl_pkg::cmd_type     cmd,
   output gcl_pkg::status_type  status,
   input  logic [DATA_BITS-1:0] first_operand,
   input  logic [DATA_BITS-1:0] second_operand,
   output logic [DATA_BITS-1:0] gcd_value,
   output logic [DATA_BITS-1:0] lcm_value,
   output logic                 lcm_overflow
);
   import gcl_pkg::*;

   localparam int CNT_W = $clog2(DATA_BITS);
   localparam logic [DATA_BITS-1:0] VAL_MAX = '1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_BITS - 1);

   logic [DATA_BITS-1:0] a_ff, b_ff;
   logic [DATA_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [DATA_BITS-1:0] g_ff, g_in;
   logic [DATA_BITS-1:0] rem_ff, rem_in;
   logic [DATA_BITS-1:0] dq_ff, dq_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [DATA_BITS:0]   rem_shift;
   logic [DATA_BITS:0]   rem_diff;
   logic                 q_bit;
   logic [DATA_BITS+1:0] mul_sum;
   logic [DATA_BITS-1:0] gcd_full;

   // Status toward the controller.
   always_comb begin
      status.gcd_done  = (x_ff == '0) || (y_ff == '0);
      status.any_zero  = (a_ff == '0) || (b_ff == '0);
      status.last_step = (cnt_ff == '0);
   end

   // Once one value is zero the other one carries the odd part of the gcd.
   assign gcd_full = (x_ff | y_ff) << k_ff;

   // Restoring divide of the first operand by the gcd.
   always_comb begin
      rem_shift = {rem_ff, dq_ff[DATA_BITS-1]};
      rem_diff  = rem_shift - {1'b0, g_ff};
      q_bit     = ~rem_diff[DATA_BITS];
   end

   // Shift and add multiply, quotient bits taken from the top.
   assign mul_sum = {1'b0, acc_ff, 1'b0}
                  + (dq_ff[DATA_BITS-1] ? {2'b00, b_ff} : '0);

   // Next values of the working registers.
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      rem_in = rem_ff;
      dq_in  = dq_ff;
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;

      if (cmd.load) begin
         x_in = first_operand;
         y_in = second_operand;
         k_in = '0;
      end

      // Binary gcd: strip common twos, strip single twos, subtract odd values.
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end

      if (cmd.div_start) begin
         g_in   = gcd_full;
         rem_in = '0;
         dq_in  = a_ff;
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? rem_diff[DATA_BITS-1:0] : rem_shift[DATA_BITS-1:0];
         dq_in  = {dq_ff[DATA_BITS-2:0], q_bit};
      end

      if (cmd.mul_step) begin
         acc_in = mul_sum[DATA_BITS-1:0];
         // The running product never shrinks, so the flag is sticky.
         if (mul_sum[DATA_BITS+1:DATA_BITS] != 2'b00) begin
            ovf_in = 1'b1;
         end
         dq_in = dq_ff << 1;
      end

      if (cmd.mul_start) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end

      // One counter paces both the divide and the multiply.
      if (cmd.div_start || cmd.mul_start) begin
         cnt_in = LAST_CNT;
      end else if (cmd.div_step || cmd.mul_step) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= first_operand;
         b_ff <= second_operand;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   // Result selection.
   always_comb begin
      gcd_value = g_ff;
      if (status.any_zero) begin
         lcm_value    = '0;
         lcm_overflow = 1'b0;
      end else begin
         lcm_value    = ovf_ff ? VAL_MAX : acc_ff;
         lcm_overflow = ovf_ff;
      end
   end

endmodule

// ===== rtl/gcd_lcm_unit_top.sv =====
// Greatest common divisor and least common multiple of two unsigned operands.
//
// Input channel req_*: one transfer carries both operands. Result channel rsp_*:
// one transfer per input with the gcd, the lcm (saturated to all ones) and an
// overflow flag. A zero operand gives the other operand as gcd and a zero lcm.
//
// Steps from the input transfer to rsp_tvalid: binary gcd steps (none with a
// zero operand), latching the gcd, a restoring divide (lcm quotient a/gcd), a
// shift and add multiply by b, then loading the result register. The gcd,
// divide and multiply share one datapath. With a zero operand the divide and
// multiply are skipped. One item is worked on at a time and the input reopens
// in the cycle after the result register is loaded.
//
// Reset returns the controller to idle and empties the result register. A
// stalled receiver does not stop the next item from being taken and computed,
// but that item waits at the end of its computation until the held result has
// been transferred.
module gcd_lcm_unit_top #(
   parameter int DATA_BITS = gcl_pkg::DATA_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_operand, second_operand
   input  logic [((2*DATA_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // gcd_value, lcm_value, lcm_overflow
   output logic [((2*DATA_BITS+8)/8)*8-1:0] rsp_tdata
);
   import gcl_pkg::*;

   localparam int OUT_W = ((2*DATA_BITS+8)/8)*8;

   cmd_type              cmd;
   status_type           status;
   logic                 out_free;
   logic                 out_load;
   logic [DATA_BITS-1:0] gcd_value;
   logic [DATA_BITS-1:0] lcm_value;
   logic                 lcm_overflow;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_gcd_ff, rsp_lcm_ff;
   logic                 rsp_ovf_ff;

   gcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .out_load  (out_load),
      .status    (status),
      .cmd       (cmd)
   );

   gcl_datapath #(
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .first_operand  (req_tdata[DATA_BITS-1:0]),
      .second_operand (req_tdata[2*DATA_BITS-1:DATA_BITS]),
      .gcd_value      (gcd_value),
      .lcm_value      (lcm_value),
      .lcm_overflow   (lcm_overflow)
   );

   // Result register: free when empty or when its content leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_gcd_ff <= gcd_value;
         rsp_lcm_ff <= lcm_value;
         rsp_ovf_ff <= lcm_overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_ovf_ff, rsp_lcm_ff, rsp_gcd_ff});

   // An accepted item keeps the input closed until its work is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after a transfer");

   // A new result never overwrites one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while held");

   // An overflowing lcm is reported as the saturated value.
   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_lcm_ff == '1))
      else $error("overflow without saturated lcm");

   // A zero gcd means both operands were zero, so the lcm is zero too.
   a_zero_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_gcd_ff == '0)) |-> ((rsp_lcm_ff == '0) && !rsp_ovf_ff))
      else $error("zero gcd with nonzero lcm");

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = gcl_pkg::DATA_BITS_DEF;
   localparam int REQ_W = ((2*DW+7)/8)*8;
   localparam int RSP_W = ((2*DW+8)/8)*8;
   localparam logic [DW-1:0] OPND_MAX = '1;
   localparam logic [DW-1:0] HALF_RANGE = DW'(1) << (DW-1);
   // Longest single item: load, gcd steps, divide, multiply, unload.
   localparam int ITEM_CYCLES = 6*DW + 8;
   localparam int ITEMS_PER_PHASE = 650;
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam int NUM_DIRECTED = 21;

   // Result of one operand pair, as carried on the result channel.
   typedef struct packed {
      logic [DW-1:0] gcd;
      logic [DW-1:0] lcm;
      logic          ovf;
   } gcd_lcm_type;

   // One directed row; typed rows carry the result that is read off at a glance.
   typedef struct packed {
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic          typed;
      gcd_lcm_type   res;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   gcd_lcm_type pending_results[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int results_checked = 0;
   int overflow_seen = 0;
   int zero_operand_pairs = 0;
   longint cycle_count = 0;

   pair_row_type directed_rows [NUM_DIRECTED] = '{
      '{31'h0, 31'h0, 1'b1, '{31'h0, 31'h0, 1'b0}},
      '{31'h0, OPND_MAX, 1'b1, '{OPND_MAX, 31'h0, 1'b0}},
      '{OPND_MAX, 31'h0, 1'b1, '{OPND_MAX, 31'h0, 1'b0}},
      '{31'h0, 31'h1, 1'b1, '{31'h1, 31'h0, 1'b0}},
      '{HALF_RANGE, 31'h0, 1'b1, '{HALF_RANGE, 31'h0, 1'b0}},
      '{31'h1, 31'h1, 1'b1, '{31'h1, 31'h1, 1'b0}},
      '{OPND_MAX, OPND_MAX, 1'b1, '{OPND_MAX, OPND_MAX, 1'b0}},
      '{31'h1, OPND_MAX, 1'b1, '{31'h1, OPND_MAX, 1'b0}},
      '{OPND_MAX, 31'h1, 1'b1, '{31'h1, OPND_MAX, 1'b0}},
      '{OPND_MAX, OPND_MAX - 31'h1, 1'b1, '{31'h1, OPND_MAX, 1'b1}},
      '{HALF_RANGE, HALF_RANGE, 1'b1, '{HALF_RANGE, HALF_RANGE, 1'b0}},
      '{HALF_RANGE, 31'h2, 1'b1, '{31'h2, HALF_RANGE, 1'b0}},
      '{HALF_RANGE, 31'h3, 1'b1, '{31'h1, OPND_MAX, 1'b1}},
      // The lcm lands just below the top of the range, then near twice the top.
      '{31'h2, 31'h3FFF_FFFF, 1'b0, '0},
      '{31'h4, 31'h3FFF_FFFF, 1'b0, '0},
      '{31'd12, 31'd18, 1'b0, '0},
      '{31'd65536, 31'd65537, 1'b0, '0},
      '{31'd46340, 31'd46341, 1'b0, '0},
      // Consecutive Fibonacci numbers take the most remainder steps.
      '{31'd1134903170, 31'd701408733, 1'b0, '0},
      '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
      '{OPND_MAX - 31'h1, OPND_MAX - 31'h1, 1'b0, '0}
   };

   gcd_lcm_unit_top #(.DATA_BITS(DW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Euclid's remainder loop, then the lcm as (a / gcd) * b with saturation.
   function automatic gcd_lcm_type compute_gcd_lcm(input logic [DW-1:0] a,
                                                   input logic [DW-1:0] b);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] rem;
      logic [63:0] quot;
      logic [63:0] top;
      gcd_lcm_type res;
      x = 64'(a);
      y = 64'(b);
      top = 64'(OPND_MAX);
      while (y != 0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      res.gcd = x[DW-1:0];
      res.lcm = '0;
      res.ovf = 1'b0;
      if (a != 0 && b != 0) begin
         quot = 64'(a) / x;
         if (quot > top / 64'(b)) begin
            res.lcm = OPND_MAX;
            res.ovf = 1'b1;
         end else begin
            res.lcm = DW'(quot * 64'(b));
         end
      end
      return res;
   endfunction

   // Random operand pair, weighted toward shared factors and narrow values.
   task automatic pick_random_pair(output logic [DW-1:0] a, output logic [DW-1:0] b);
      int unsigned sel;
      int unsigned g;
      int unsigned wa;
      int unsigned wb;
      logic [DW-1:0] tmp;
      sel = $urandom_range(99);
      if (sel < 35) begin
         g = $urandom_range(1, 1 << $urandom_range(0, 16));
         a = DW'(g * $urandom_range(1, int'(OPND_MAX) / g));
         b = DW'(g * ($urandom_range(1, int'(OPND_MAX) / g) >> $urandom_range(0, DW-1)));
      end else if (sel < 65) begin
         wa = $urandom_range(1, DW);
         wb = $urandom_range(1, DW);
         a = DW'($urandom & ((32'h1 << wa) - 1));
         b = DW'($urandom & ((32'h1 << wb) - 1));
      end else if (sel < 80) begin
         a = DW'($urandom);
         b = DW'($urandom);
      end else if (sel < 90) begin
         a = ($urandom_range(3) == 0) ? '0 : DW'($urandom >> $urandom_range(0, DW-1));
         b = '0;
      end else begin
         a = DW'(1) << $urandom_range(0, DW-1);
         b = $urandom_range(1) ? OPND_MAX - DW'($urandom_range(0, 7))
                               : DW'($urandom_range(0, 3));
      end
      if ($urandom_range(1)) begin
         tmp = a;
         a = b;
         b = tmp;
      end
   endtask

   // Offer one pair with random gaps and record its result once the transfer happens.
   task automatic send_pair(input logic [DW-1:0] a, input logic [DW-1:0] b,
                            input gcd_lcm_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({b, a});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(res);
      if (a == 0 || b == 0) zero_operand_pairs++;
   endtask

   // Hold the input channel quiet until every outstanding result has arrived.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver backpressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each result transfer with the oldest pending expectation.
   always @(posedge clock) begin
      gcd_lcm_type want;
      gcd_lcm_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.gcd = rsp_tdata[DW-1:0];
         got.lcm = rsp_tdata[2*DW-1:DW];
         got.ovf = rsp_tdata[2*DW];
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result with none pending: gcd %0d lcm %0d ovf %0d",
                     $time, got.gcd, got.lcm, got.ovf);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.ovf) overflow_seen++;
            if (got.gcd !== want.gcd) begin
               error_count++;
               $display("%0t: gcd expected %0d actual %0d", $time, want.gcd, got.gcd);
            end
            if (got.lcm !== want.lcm) begin
               error_count++;
               $display("%0t: lcm expected %0d actual %0d", $time, want.lcm, got.lcm);
            end
            if (got.ovf !== want.ovf) begin
               error_count++;
               $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, got.ovf);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, pending_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus: directed rows, then three random phases with different idling.
   initial begin
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].typed ? directed_rows[i].res
                                          : compute_gcd_lcm(directed_rows[i].a,
                                                            directed_rows[i].b));
      end
      wait_results_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_stall_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_stall_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick_random_pair(a, b);
            send_pair(a, b, compute_gcd_lcm(a, b));
         end
         wait_results_drained();
      end

      // Give a stray extra result time to show up.
      repeat (ITEM_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      end

      $display("Checked %0d results: %0d with a saturated lcm, %0d with a zero operand.",
               results_checked, overflow_seen, zero_operand_pairs);
      $display("Random pairs ran under sender gaps, receiver stalls and back-to-back flow.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gcl_pkg.sv
rtl/gcl_ctrl.sv
rtl/gcl_datapath.sv
rtl/gcd_lcm_unit_top.sv
bench/tb.sv
